[sv/s5rp_pkg.sv]
// s5rp_pkg: constants and types shared by the SOCKS5 request parser and its checker.
// No dependencies.
package s5rp_pkg;

	localparam logic [7:0] SOCKS_VERSION = 8'h05;
	localparam logic [7:0] ATYP_V4       = 8'd1;
	localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
	localparam logic [7:0] ATYP_V6       = 8'd4;
	localparam logic [7:0] LEN_V4        = 8'd4;
	localparam logic [7:0] LEN_V6        = 8'd16;

	typedef enum logic [1:0] {
		ST_BUSY  = 2'd0,
		ST_DONE  = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

endpackage

[sv/socks5_request_parser.sv]
// socks5_request_parser: byte-serial SOCKS5 request parser, one result per input byte.
// Depends on s5rp_pkg.
// Each accepted byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle while out_ready does not stall the result; the phase update is the only loop.
// Input side keeps accepting while a result waits, until both registers hold a transaction.
// Reset (arst_n low, asynchronous): parser returns to the version phase, all registers clear.
module socks5_request_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              data_byte,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              status,
	output logic                    finished,
	output logic                    has_error,
	output logic                    rejected,
	output logic [7:0]              command,
	output logic [7:0]              address_type,
	output logic                    addr_valid,
	output logic [7:0]              addr_byte,
	output logic [7:0]              addr_index,
	output logic [15:0]             dest_port
);
	import s5rp_pkg::*;

	typedef enum logic [3:0] {
		PH_VERSION  = 4'd0,
		PH_CMD      = 4'd1,
		PH_RSV      = 4'd2,
		PH_ATYPE    = 4'd3,
		PH_ADDR_DOM = 4'd4,
		PH_ADDR_FIX = 4'd5,
		PH_PORT_HI  = 4'd6,
		PH_PORT_LO  = 4'd7,
		PH_DONE     = 4'd8,
		PH_ERROR    = 4'd9
	} phase_t;

	// input stage
	logic       valid_s1;
	logic [7:0] data_s1;

	// parser state
	phase_t      phase_q;
	logic [7:0]  cmd_q;
	logic [7:0]  atype_q;
	logic [7:0]  addr_len_q;
	logic [7:0]  addr_pos_q;
	logic        len_seen_q;
	logic [15:0] port_q;

	// result register
	logic        out_valid_q;
	status_t     status_q;
	logic        rejected_q;
	logic        addr_valid_q;
	logic [7:0]  addr_byte_q;
	logic [7:0]  addr_index_q;
	logic [15:0] dest_port_q;

	// next-state / result logic
	phase_t      phase_n;
	logic [7:0]  cmd_n;
	logic [7:0]  atype_n;
	logic [7:0]  addr_len_n;
	logic [7:0]  addr_pos_n;
	logic        len_seen_n;
	logic [15:0] port_n;
	logic        rej_n;
	logic        av_n;
	logic [7:0]  ab_n;
	logic [7:0]  ai_n;
	logic        take_addr;
	logic [7:0]  pos_inc;
	status_t     status_n;
	logic        advance;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign pos_inc  = addr_pos_q + 8'd1;

	always_comb begin
		phase_n    = phase_q;
		cmd_n      = cmd_q;
		atype_n    = atype_q;
		addr_len_n = addr_len_q;
		addr_pos_n = addr_pos_q;
		len_seen_n = len_seen_q;
		port_n     = port_q;
		rej_n      = 1'b0;
		take_addr  = 1'b0;
		unique case (phase_q)
			PH_VERSION: begin
				phase_n = (data_s1 == SOCKS_VERSION) ? PH_CMD : PH_ERROR;
			end
			PH_CMD: begin
				cmd_n   = data_s1;
				phase_n = PH_RSV;
			end
			PH_RSV: begin
				phase_n = PH_ATYPE;
			end
			PH_ATYPE: begin
				atype_n = data_s1;
				// unknown type: stay here and take the next byte as a type again
				if (data_s1 == ATYP_V4) begin
					phase_n    = PH_ADDR_FIX;
					addr_len_n = LEN_V4;
				end else if (data_s1 == ATYP_V6) begin
					phase_n    = PH_ADDR_FIX;
					addr_len_n = LEN_V6;
				end else if (data_s1 == ATYP_DOMAIN) begin
					phase_n = PH_ADDR_DOM;
				end
			end
			PH_ADDR_DOM: begin
				if (!len_seen_q) begin
					// a zero length byte is skipped
					if (data_s1 != 8'd0) begin
						addr_len_n = data_s1;
						len_seen_n = 1'b1;
					end
				end else begin
					take_addr = 1'b1;
				end
			end
			PH_ADDR_FIX: begin
				take_addr = 1'b1;
			end
			PH_PORT_HI: begin
				port_n  = {data_s1, 8'd0};
				phase_n = PH_PORT_LO;
			end
			PH_PORT_LO: begin
				port_n  = {port_q[15:8], data_s1};
				phase_n = PH_DONE;
			end
			default: begin
				rej_n = 1'b1;
			end
		endcase

		av_n = take_addr;
		ab_n = take_addr ? data_s1 : 8'd0;
		ai_n = take_addr ? addr_pos_q : 8'd0;
		if (take_addr) begin
			addr_pos_n = pos_inc;
			if (pos_inc == addr_len_q)
				phase_n = PH_PORT_HI;
		end

		priority if (phase_n == PH_DONE)
			status_n = ST_DONE;
		else if (phase_n == PH_ERROR)
			status_n = ST_ERROR;
		else
			status_n = ST_BUSY;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			data_s1      <= 8'd0;
			phase_q      <= PH_VERSION;
			cmd_q        <= 8'd0;
			atype_q      <= 8'd0;
			addr_len_q   <= 8'd0;
			addr_pos_q   <= 8'd0;
			len_seen_q   <= 1'b0;
			port_q       <= 16'd0;
			out_valid_q  <= 1'b0;
			status_q     <= ST_BUSY;
			rejected_q   <= 1'b0;
			addr_valid_q <= 1'b0;
			addr_byte_q  <= 8'd0;
			addr_index_q <= 8'd0;
			dest_port_q  <= 16'd0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
				if (in_valid)
					data_s1 <= data_byte;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
				if (valid_s1) begin
					phase_q      <= phase_n;
					cmd_q        <= cmd_n;
					atype_q      <= atype_n;
					addr_len_q   <= addr_len_n;
					addr_pos_q   <= addr_pos_n;
					len_seen_q   <= len_seen_n;
					port_q       <= port_n;
					status_q     <= status_n;
					rejected_q   <= rej_n;
					addr_valid_q <= av_n;
					addr_byte_q  <= ab_n;
					addr_index_q <= ai_n;
					dest_port_q  <= (status_n == ST_DONE) ? port_n : 16'd0;
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign finished     = (status_q != ST_BUSY);
	assign has_error    = (status_q == ST_ERROR);
	assign rejected     = rejected_q;
	assign command      = cmd_q;
	assign address_type = atype_q;
	assign addr_valid   = addr_valid_q;
	assign addr_byte    = addr_byte_q;
	assign addr_index   = addr_index_q;
	assign dest_port    = dest_port_q;

endmodule

[sv/s5rp_checker.sv]
// s5rp_checker: port-level assertions for socks5_request_parser, bound into that module.
// Depends on s5rp_pkg.
module s5rp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic        finished,
	input logic        has_error,
	input logic        rejected,
	input logic        addr_valid,
	input logic [7:0]  addr_byte,
	input logic [7:0]  addr_index,
	input logic [15:0] dest_port
);
	import s5rp_pkg::*;

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (finished == (status != ST_BUSY)) && (has_error == (status == ST_ERROR)))
		else $error("finished/has_error disagree with status");

	a_reject_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> finished && !addr_valid)
		else $error("rejected transaction while parse still open");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !addr_valid |-> (addr_byte == 8'd0) && (addr_index == 8'd0))
		else $error("address fields nonzero without addr_valid");

	a_port_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_DONE) |-> dest_port == 16'd0)
		else $error("dest_port shown before request complete");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(addr_byte)
			&& $stable(dest_port))
		else $error("stalled result changed");

endmodule

bind socks5_request_parser s5rp_checker u_s5rp_checker (.*);
